// File: rtl/hasf_pkg.sv
// Package for the Hilbert analytic-signal FIR: default sizes, fixed-point
// constants, the MAC control struct and the elaboration-time coefficient builder.
// No dependencies; the interfaces, the MAC and the top level use it.
package hasf_pkg;

  localparam int TAPS_DEF        = 101;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_FRAC       = 17;  // Q1.17 coefficients
  localparam int COEF_BITS       = 18;

  localparam logic [63:0] Q30_ONE         = 64'd1073741824;
  localparam logic [63:0] PI_Q30          = 64'd3373259426;
  localparam logic [63:0] TWO_OVER_PI_Q30 = 64'd683565276;

  // Control from the sequencer to the MAC datapath
  typedef struct packed {
    logic clr;      // clear accumulator (new item)
    logic tap_vld;  // read data carries a tap sample this cycle
    logic ent_vld;  // history entry has been written since reset
    logic fin;      // latch final (optionally negated) sum
    logic inv;      // negate imaginary output
  } mac_ctl_t;

  // Restoring division, evaluated at elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // cos(pi*p/m) in Q30 for 0 <= p/m <= 1/2, Taylor series
  function automatic logic [63:0] cos_q30(logic [63:0] p, logic [63:0] m);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] c;
    x  = udiv64(PI_Q30 * p, m);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    c  = $signed(Q30_ONE);
    for (int k = 1; k <= 12; k++) begin
      t = udiv64((t * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
      if ((k % 2) == 1) begin
        c = c - $signed(t);
      end else begin
        c = c + $signed(t);
      end
    end
    if (c < 0) begin
      c = '0;
    end
    return $unsigned(c);
  endfunction

  // Signed cos(2*pi*i/m) in Q30 for 0 <= i <= m
  function automatic logic signed [63:0] window_cos(logic [63:0] i, logic [63:0] m);
    logic [63:0] r;
    r = ((2 * i) > m) ? (m - i) : i;
    if ((4 * r) > m) begin
      return -$signed(cos_q30(m - 2 * r, m));
    end
    return $signed(cos_q30(2 * r, m));
  endfunction

  // Hamming-windowed Hilbert coefficient for tap idx (0 = newest sample)
  function automatic logic signed [COEF_BITS-1:0] coef_calc(int taps, int idx);
    int                 mid;
    int                 n;
    logic [63:0]        an;
    logic [63:0]        m;
    logic [63:0]        w;
    logic [63:0]        p;
    logic [63:0]        v;
    logic signed [63:0] cv;
    logic signed [63:0] num;
    mid = taps / 2;
    n   = idx - mid;
    an  = 64'((n < 0) ? -n : n);
    if (an[0] == 1'b0) begin
      return '0;
    end
    m   = 64'(taps - 1);
    cv  = window_cos(64'(idx), m);
    num = 64'sd54 * $signed(Q30_ONE) - 64'sd46 * cv;
    w   = $unsigned(num) / 100;
    p   = w * TWO_OVER_PI_Q30;
    v   = udiv64(p + (an << 42), an << 43);
    return (n < 0) ? COEF_BITS'(-v) : COEF_BITS'(v);
  endfunction

endpackage

// File: rtl/hasf_in_if.sv
// Input channel of the Hilbert analytic-signal FIR: valid/ready plus sample payload.
// Depends on hasf_pkg for the default sample width.
interface hasf_in_if #(
  parameter int SAMPLE_BITS = hasf_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_in_block;

  modport source (output valid, output sample, output last_in_block, input ready);
  modport sink   (input valid, input sample, input last_in_block, output ready);
endinterface

// File: rtl/hasf_out_if.sv
// Output channel of the Hilbert analytic-signal FIR: valid/ready plus complex result.
// Depends on hasf_pkg for the default sample width.
interface hasf_out_if #(
  parameter int SAMPLE_BITS = hasf_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] real_part;
  logic signed [SAMPLE_BITS-1:0] imag_part;
  logic                          last_in_block_res;

  modport source (output valid, output real_part, output imag_part,
                  output last_in_block_res, input ready);
  modport sink   (input valid, input real_part, input imag_part,
                  input last_in_block_res, output ready);
endinterface

// File: rtl/hasf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module hasf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 101
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/hasf_mac.sv
// Multiply-accumulate datapath of the Hilbert FIR: product register, accumulator,
// optional negation, round half up and saturate. Depends on hasf_pkg.
module hasf_mac #(
  parameter int TAPS        = hasf_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = hasf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hasf_pkg::mac_ctl_t                   ctl_i,
  input  logic signed [SAMPLE_BITS-1:0]        data_i,
  input  logic signed [hasf_pkg::COEF_BITS-1:0] coef_i,
  output logic signed [SAMPLE_BITS-1:0]        imag_o,
  output logic                                 busy_o
);

  localparam int PW       = SAMPLE_BITS + hasf_pkg::COEF_BITS;
  localparam int ACC_BITS = PW + $clog2(TAPS);
  localparam int AN       = ACC_BITS + 1;
  localparam int RW       = AN - hasf_pkg::COEF_FRAC;

  localparam logic signed [AN-1:0] HALF   = AN'(1) << (hasf_pkg::COEF_FRAC - 1);
  localparam logic signed [RW-1:0] SAT_HI =
    {{(RW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO =
    {{(RW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] data_m;
  logic signed [PW-1:0]          prod_q;
  logic                          p_vld_q;
  logic signed [ACC_BITS-1:0]    acc_q;
  logic signed [AN-1:0]          accn_q;
  logic signed [AN-1:0]          rnd_sum;
  logic signed [RW-1:0]          rnd;

  // Unwritten history entries read as zero
  assign data_m = ctl_i.ent_vld ? data_i : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= ctl_i.tap_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= data_m * coef_i;
    if (ctl_i.clr) begin
      acc_q <= '0;
    end else if (p_vld_q) begin
      acc_q <= acc_q + ACC_BITS'(prod_q);
    end
    if (ctl_i.fin) begin
      accn_q <= ctl_i.inv ? -AN'(acc_q) : AN'(acc_q);
    end
  end

  assign rnd_sum = accn_q + HALF;
  assign rnd     = rnd_sum[AN-1:hasf_pkg::COEF_FRAC];

  always_comb begin
    if (rnd > SAT_HI) begin
      imag_o = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rnd < SAT_LO) begin
      imag_o = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      imag_o = rnd[SAMPLE_BITS-1:0];
    end
  end

  assign busy_o = p_vld_q;

endmodule

// File: rtl/hilbert_analytic_signal_fir.sv
// Hilbert analytic-signal FIR: turns a real sample stream into a complex one.
// Depends on hasf_pkg, hasf_in_if, hasf_out_if, hasf_ram and hasf_mac.
//
// Each accepted sample is written into a circular history of TAPS entries held
// in one RAM. The real output is the sample taken TAPS/2 items earlier; the
// imaginary output is a Hamming-windowed Hilbert FIR over the history, using
// only the taps at odd offsets from the center (the rest are zero), rounded
// half up and saturated to SAMPLE_BITS. Setting invert_spectrum (cfg_we_i with
// cfg_wdata_i) negates the imaginary output; write it only while idle. The
// history reads as zero where it has not been written since reset; a write
// pointer and a "full" flag stand in for clearing the RAM, so no clearing pass
// is needed. One item is worked on at a time: the history RAM has a single read
// port which feeds one tap per cycle into one multiplier (NZ = nonzero taps, 50
// for 101 taps); each item takes one read for the real output, NZ tap reads,
// the read/multiply/accumulate pipeline drain and the final round before the
// next item can be accepted. The result shows on the same edge that makes the
// input ready again; a result waiting downstream holds the block in its done
// state, so the next item is not accepted until the output register frees.
module hilbert_analytic_signal_fir #(
  parameter int TAPS        = hasf_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = hasf_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  hasf_in_if.sink   in_i,
  hasf_out_if.source out_o
);

  localparam int AW     = $clog2(TAPS);
  localparam int MID    = TAPS / 2;
  // first tap with an odd offset from the center, then every second tap
  localparam int K0     = ((MID % 2) == 1) ? 0 : 1;
  localparam int NZ     = (TAPS - K0 + 1) / 2;
  localparam int K_LAST = K0 + 2 * (NZ - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // write pointer and fill state of the history
  logic [AW-1:0] pos_q;
  logic          full_q;

  // read sequencing
  logic [AW-1:0] ridx_q;
  logic [AW-1:0] a_q;
  logic [AW-1:0] k_q;
  logic          real_ph_q;

  logic          inv_q;
  logic          last_q;

  // read stage: address issued last cycle, data now at the RAM output
  logic                                  s1_vld_q;
  logic                                  s1_real_q;
  logic                                  s1_ent_q;
  logic signed [hasf_pkg::COEF_BITS-1:0] coef_s1_q;

  logic signed [SAMPLE_BITS-1:0] real_q;

  logic                          out_vld_q;
  logic signed [SAMPLE_BITS-1:0] out_real_q;
  logic signed [SAMPLE_BITS-1:0] out_imag_q;
  logic                          out_last_q;

  logic                          accept;
  logic                          rd_en;
  logic [AW-1:0]                 raddr;
  logic                          ent_vld;
  logic                          last_issue;
  logic                          drained;
  logic                          load;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic signed [SAMPLE_BITS-1:0] imag;
  logic                          mac_busy;
  hasf_pkg::mac_ctl_t            mac_ctl;

  logic signed [hasf_pkg::COEF_BITS-1:0] coef_rom [TAPS];

  // Coefficient table, fixed at elaboration
  for (genvar g = 0; g < TAPS; g++) begin : g_coef
    localparam logic signed [hasf_pkg::COEF_BITS-1:0] C = hasf_pkg::coef_calc(TAPS, g);
    assign coef_rom[g] = C;
  end

  assign accept     = in_i.valid & in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // First read of an item fetches the real output, then one tap per cycle
  assign rd_en      = (state_q == S_ISSUE);
  assign raddr      = real_ph_q ? ridx_q : a_q;
  // Entries at and above the write pointer are unwritten until the first wrap
  assign ent_vld    = full_q | (raddr < pos_q);
  assign last_issue = rd_en & ~real_ph_q & (k_q == AW'(K_LAST));
  assign drained    = ~s1_vld_q & ~mac_busy;
  assign load       = (state_q == S_DONE) & (~out_vld_q | out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (last_issue) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drained) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pos_q     <= '0;
      full_q    <= 1'b0;
      ridx_q    <= '0;
      a_q       <= '0;
      k_q       <= '0;
      real_ph_q <= 1'b0;
      inv_q     <= 1'b0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= rd_en;
      if (cfg_we_i) begin
        inv_q <= cfg_wdata_i;
      end
      if (accept) begin
        // advance the write pointer; mark full on the first wrap
        if (pos_q == AW'(TAPS - 1)) begin
          pos_q  <= '0;
          full_q <= 1'b1;
        end else begin
          pos_q <= pos_q + AW'(1);
        end
        ridx_q    <= (pos_q >= AW'(MID)) ? (pos_q - AW'(MID)) : (pos_q + AW'(TAPS - MID));
        a_q       <= (pos_q >= AW'(K0)) ? (pos_q - AW'(K0)) : (pos_q + AW'(TAPS - K0));
        k_q       <= AW'(K0);
        real_ph_q <= 1'b1;
      end else if (rd_en) begin
        if (real_ph_q) begin
          real_ph_q <= 1'b0;
        end else begin
          // step two taps back through the circular history
          k_q <= k_q + AW'(2);
          a_q <= (a_q >= AW'(2)) ? (a_q - AW'(2)) : (a_q + AW'(TAPS - 2));
        end
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q <= in_i.last_in_block;
    end
    s1_real_q <= real_ph_q;
    s1_ent_q  <= ent_vld;
    coef_s1_q <= coef_rom[k_q];
    if (s1_vld_q && s1_real_q) begin
      real_q <= s1_ent_q ? $signed(ram_rdata) : '0;
    end
    if (load) begin
      out_real_q <= real_q;
      out_imag_q <= imag;
      out_last_q <= last_q;
    end
  end

  // The sample is written at the accept edge and read in later cycles only,
  // so the newest tap always sees the new value without forwarding.
  hasf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TAPS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (pos_q),
    .wdata_i (in_i.sample),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    mac_ctl.clr     = accept;
    mac_ctl.tap_vld = s1_vld_q & ~s1_real_q;
    mac_ctl.ent_vld = s1_ent_q;
    mac_ctl.fin     = (state_q == S_DRAIN) & drained;
    mac_ctl.inv     = inv_q;
  end

  hasf_mac #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .data_i ($signed(ram_rdata)),
    .coef_i (coef_s1_q),
    .imag_o (imag),
    .busy_o (mac_busy)
  );

  assign out_o.valid             = out_vld_q;
  assign out_o.real_part         = out_real_q;
  assign out_o.imag_part         = out_imag_q;
  assign out_o.last_in_block_res = out_last_q;

endmodule

// File: rtl/hasf_chk.sv
// Port-level checker for the Hilbert analytic-signal FIR, bound to the top level.
// Depends on hasf_in_if and hasf_out_if.
module hasf_chk (
  input logic        clk_i,
  input logic        rst_ni,
  hasf_in_if.sink    in_i,
  hasf_out_if.source out_o
);

  // One item at a time: ready does not return right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (!in_i.ready ##1 !in_i.ready))
    else $error("input ready returned too soon after an accepted item");

  // A new result is published exactly when the block returns to accepting
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> in_i.ready)
    else $error("result published while an item is still in work");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=>
      (out_o.valid && $stable(out_o.real_part) && $stable(out_o.imag_part) &&
       $stable(out_o.last_in_block_res)))
    else $error("stalled result changed");

endmodule

bind hilbert_analytic_signal_fir hasf_chk u_hasf_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
